/* rtl/core/sha256_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash values, round helpers and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned ROUNDS   = 64;
   localparam int unsigned BLK_WRDS = 16;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS  = 6'd56;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // byte source for a buffer write
   typedef enum logic [1:0] {
      SRC_DATA, SRC_PAD, SRC_ZERO, SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         wr_byte;     // write one byte at the fill position
      byte_src_type src;
      logic         count_bit;   // add 8 to the bit count
      logic         start_blk;   // load working vars, clear round counter
      logic         do_round;    // one compression round
      logic         fold;        // add working vars into hash
      logic         restart;     // back to initial hash, count zero
      logic         clr_pos;     // restart fill position
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] pos;
      logic       last_round;
   } dp_stat_type;

   function automatic word_type rotr(input word_type v, input int unsigned s);
      rotr = (v >> s) | (v << (WORD_W - s));
   endfunction

endpackage

/* rtl/core/sha256_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Byte buffer as 16-word schedule window, hash state, bit count and one
// compression round per cycle.
// ----------------------------------------------------------------------------
module sha256_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::dp_cmd_type cmd,
   input  logic [7:0]             data_byte,
   output sha256_pkg::dp_stat_type stat,
   output logic [255:0]           digest
);

   sha256_pkg::word_type w_ff [16];
   sha256_pkg::word_type w_in [16];
   sha256_pkg::word_type h_ff [8];
   sha256_pkg::word_type h_in [8];
   sha256_pkg::word_type v_ff [8];
   sha256_pkg::word_type v_in [8];
   logic [63:0] cnt_ff, cnt_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [7:0]  wbyte;
   logic [2:0]  lsel;
   sha256_pkg::word_type s0, s1, wnew, t1, t2, wcur;

   always_comb begin
      lsel = pos_ff[2:0];
      case (cmd.src)
         sha256_pkg::SRC_DATA: wbyte = data_byte;
         sha256_pkg::SRC_PAD:  wbyte = sha256_pkg::PAD_BYTE;
         sha256_pkg::SRC_ZERO: wbyte = 8'h00;
         sha256_pkg::SRC_LEN:  wbyte = cnt_ff[63 - 8*lsel -: 8];
         default:              wbyte = 8'h00;
      endcase
      wcur = w_ff[0];
      s0 = sha256_pkg::rotr(w_ff[1], 7) ^ sha256_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha256_pkg::rotr(w_ff[14], 17) ^ sha256_pkg::rotr(w_ff[14], 19)
         ^ (w_ff[14] >> 10);
      wnew = s1 + w_ff[9] + s0 + w_ff[0];
      t1 = v_ff[7] + (sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
         ^ sha256_pkg::rotr(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha256_pkg::ROUND_K[rnd_ff] + wcur;
      t2 = (sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
         ^ sha256_pkg::rotr(v_ff[0], 22)) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
         ^ (v_ff[1] & v_ff[2]));

      w_in = w_ff; h_in = h_ff; v_in = v_ff;
      cnt_in = cnt_ff; pos_in = pos_ff; rnd_in = rnd_ff;
      if (cmd.wr_byte) begin
         w_in[pos_ff[5:2]][31 - 8*pos_ff[1:0] -: 8] = wbyte;
         pos_in = pos_ff + 6'd1;
      end
      if (cmd.count_bit) cnt_in = cnt_ff + 64'd8;
      if (cmd.start_blk) begin
         v_in = h_ff;
         rnd_in = '0;
      end
      if (cmd.do_round) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wnew;
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         rnd_in = rnd_ff + 6'd1;
      end
      if (cmd.fold)
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
      if (cmd.clr_pos) pos_in = '0;
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      rnd_ff <= rnd_in;
      if (reset || cmd.restart) begin
         h_ff   <= sha256_pkg::START_HASH;
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         h_ff   <= h_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   assign stat.pos = pos_ff;
   assign stat.last_round = (rnd_ff == 6'd63);
   assign digest = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4], h_ff[5], h_ff[6], h_ff[7]};

endmodule

/* rtl/core/sha256_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorb, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    byte_valid,
   input  logic                    last_item,
   input  sha256_pkg::dp_stat_type stat,
   output sha256_pkg::dp_cmd_type  cmd,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [1:0]              out_idx
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_FILL, ST_OUT
   } state_type;

   state_type  state_ff;
   logic       fin_ff;      // padding pending after this block
   logic       final_ff;    // this block is the last one
   logic [1:0] idx_ff;
   logic       ovalid_ff;
   logic       pad2_ff;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = ovalid_ff;
   assign out_idx   = idx_ff;

   always_comb begin
      cmd = '0;
      cmd.src = sha256_pkg::SRC_DATA;
      case (state_ff)
         ST_IDLE: if (in_valid && byte_valid) begin
            cmd.wr_byte = 1'b1;
            cmd.count_bit = 1'b1;
            cmd.start_blk = (stat.pos == 6'd63);
         end
         ST_ROUND: cmd.do_round = 1'b1;
         ST_FOLD: begin
            cmd.fold = 1'b1;
            cmd.clr_pos = 1'b1;
         end
         ST_PAD: begin
            cmd.wr_byte = 1'b1;
            cmd.src = sha256_pkg::SRC_PAD;
            cmd.start_blk = (stat.pos == 6'd63);
         end
         ST_FILL: begin
            cmd.wr_byte = 1'b1;
            cmd.src = (final_ff && stat.pos >= sha256_pkg::LEN_POS)
               ? sha256_pkg::SRC_LEN : sha256_pkg::SRC_ZERO;
            cmd.start_blk = (stat.pos == 6'd63);
         end
         ST_OUT: cmd.restart = out_ready && (idx_ff == 2'd3);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff <= 1'b0;
         final_ff <= 1'b0;
         idx_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: if (in_valid) begin
               fin_ff <= last_item;
               final_ff <= 1'b0;
               if (byte_valid && stat.pos == 6'd63) state_ff <= ST_ROUND;
               else if (last_item) state_ff <= ST_PAD;
            end
            ST_ROUND: if (stat.last_round) state_ff <= ST_FOLD;
            ST_FOLD: begin
               if (final_ff) begin
                  state_ff <= ST_OUT;
                  ovalid_ff <= 1'b1;
                  idx_ff <= '0;
               end else if (fin_ff) state_ff <= ST_PAD;
               // after a pad block that left no length room, fill a second block
               else if (pad2_ff) begin
                  state_ff <= ST_FILL;
                  final_ff <= 1'b1;
               end else state_ff <= ST_IDLE;
            end
            ST_PAD: begin
               fin_ff <= 1'b0;
               final_ff <= (stat.pos < 6'd56);
               if (stat.pos == 6'd63) state_ff <= ST_ROUND;
               else state_ff <= ST_FILL;
            end
            ST_FILL: if (stat.pos == 6'd63) state_ff <= ST_ROUND;
            ST_OUT: if (out_ready) begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  ovalid_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pad2_ff <= 1'b0;
      else if (state_ff == ST_PAD) pad2_ff <= (stat.pos >= 6'd56);
      else if (state_ff == ST_FOLD) pad2_ff <= 1'b0;
   end

endmodule

/* rtl/core/sha256_stream_hasher.sv */
`timescale 1ns / 1ps
// Flow: a byte that does not fill a block is absorbed directly; a full block
// then runs 64 rounds and a fold on the round unit, during which no byte is taken.
// A last item adds padding bytes at one per cycle, one or two compressions,
// then four digest words, one per accepted output cycle.
// Reset: synchronous, loads the initial hash and clears the bit count.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with padding and a four-word digest output.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast
);

   sha256_pkg::dp_cmd_type  cmd;
   sha256_pkg::dp_stat_type stat;
   logic [255:0] digest;
   logic [1:0]   idx;

   sha256_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .byte_valid(req_tuser), .last_item(req_tlast),
      .stat, .cmd,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_idx(idx)
   );

   sha256_datapath u_dp (
      .clock, .reset, .cmd, .data_byte(req_tdata), .stat, .digest
   );

   assign rsp_tdata = digest[255 - 64*idx -: 64];
   assign rsp_tuser = idx;
   assign rsp_tlast = (idx == 2'd3);

   a_no_in_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken during digest output");
   a_word_adv: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1))
      else $error("digest word index skipped");
   a_tlast_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid) else $error("extra digest word");

endmodule
